// ----- src/utv_pkg.sv -----
// Shared types and constants for the UTF-8 text validator.
package utv_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CodeWidth = 21;

   localparam logic [ByteWidth-1:0] ByteTab       = 8'h09;
   localparam logic [ByteWidth-1:0] ByteLf        = 8'h0A;
   localparam logic [ByteWidth-1:0] ByteCr        = 8'h0D;
   localparam logic [ByteWidth-1:0] ByteSpace     = 8'h20;
   localparam logic [ByteWidth-1:0] Lead2Low      = 8'hC2;
   localparam logic [ByteWidth-1:0] Lead2High     = 8'hDF;
   localparam logic [ByteWidth-1:0] Lead3Low      = 8'hE0;
   localparam logic [ByteWidth-1:0] Lead3High     = 8'hEF;
   localparam logic [ByteWidth-1:0] Lead4Low      = 8'hF0;
   localparam logic [ByteWidth-1:0] Lead4High     = 8'hF4;
   localparam logic [ByteWidth-1:0] ContMarkMask  = 8'hC0;
   localparam logic [ByteWidth-1:0] ContMark      = 8'h80;

   localparam logic [CodeWidth-1:0] MinCode2      = 21'h000080;
   localparam logic [CodeWidth-1:0] MinCode3      = 21'h000800;
   localparam logic [CodeWidth-1:0] MinCode4      = 21'h010000;
   localparam logic [CodeWidth-1:0] MaxCode       = 21'h10FFFF;
   localparam logic [CodeWidth-1:0] SurrogateLow  = 21'h00D800;
   localparam logic [CodeWidth-1:0] SurrogateHigh = 21'h00DFFF;

   // One input word as it sits in the input register.
   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 has_byte;
      logic                 is_last;
   } word_type;

   // Decoder state carried from word to word.
   typedef struct packed {
      logic [1:0]           bytes_pending;
      logic [1:0]           sequence_length;
      logic [CodeWidth-1:0] code_accumulator;
      logic                 failed;
   } dec_state_type;

endpackage

// ----- src/utv_core.sv -----
// Per-word UTF-8 decode step with the decoder state registers.
module utv_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  utv_pkg::word_type  word,
   output logic               text_valid
);
   import utv_pkg::*;

   dec_state_type        st_ff;
   dec_state_type        st_in;
   logic [ByteWidth-1:0] b;
   logic                 ctrl_bad;
   logic [CodeWidth-1:0] acc_shift;
   logic [1:0]           pend_dec;
   logic                 code_bad;

   assign b        = word.data_byte;
   assign ctrl_bad = (b < ByteSpace) && (b != ByteTab) && (b != ByteLf) && (b != ByteCr);
   assign acc_shift = {st_ff.code_accumulator[CodeWidth-7:0], b[5:0]};
   assign pend_dec  = st_ff.bytes_pending - 2'd1;

   always_comb begin
      code_bad = (acc_shift > MaxCode)
              || ((acc_shift >= SurrogateLow) && (acc_shift <= SurrogateHigh));
      case (st_ff.sequence_length)
         2'd1:    code_bad = code_bad || (acc_shift < MinCode2);
         2'd2:    code_bad = code_bad || (acc_shift < MinCode3);
         2'd3:    code_bad = code_bad || (acc_shift < MinCode4);
         default: code_bad = code_bad;
      endcase
   end

   always_comb begin
      st_in = st_ff;
      if (word.has_byte && !st_ff.failed) begin
         if (st_ff.bytes_pending == 2'd0) begin
            if (ctrl_bad) begin
               st_in.failed = 1'b1;
            end else if (!b[7]) begin
               st_in = st_ff;
            end else if ((b >= Lead2Low) && (b <= Lead2High)) begin
               st_in.bytes_pending    = 2'd1;
               st_in.sequence_length  = 2'd1;
               st_in.code_accumulator = {{(CodeWidth-5){1'b0}}, b[4:0]};
            end else if ((b >= Lead3Low) && (b <= Lead3High)) begin
               st_in.bytes_pending    = 2'd2;
               st_in.sequence_length  = 2'd2;
               st_in.code_accumulator = {{(CodeWidth-4){1'b0}}, b[3:0]};
            end else if ((b >= Lead4Low) && (b <= Lead4High)) begin
               st_in.bytes_pending    = 2'd3;
               st_in.sequence_length  = 2'd3;
               st_in.code_accumulator = {{(CodeWidth-3){1'b0}}, b[2:0]};
            end else begin
               st_in.failed = 1'b1;
            end
         end else if ((b & ContMarkMask) != ContMark) begin
            st_in.failed = 1'b1;
         end else begin
            st_in.bytes_pending    = pend_dec;
            st_in.code_accumulator = acc_shift;
            // close the sequence: range, overlong and surrogate check
            if (pend_dec == 2'd0) begin
               st_in.failed           = code_bad;
               st_in.sequence_length  = 2'd0;
               st_in.code_accumulator = '0;
            end
         end
      end
      text_valid = !st_in.failed && (st_in.bytes_pending == 2'd0);
      if (word.is_last) begin
         st_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

endmodule

// ----- src/utf8_text_validator_unit.sv -----
// Top level of the UTF-8 text validator.
//
// Checks a text, one byte per word on the req_ channel, against strict
// UTF-8 with no NUL and no control bytes other than tab, LF and CR.
// req_tdata carries the byte, req_tuser says whether the byte is real
// (a word with req_tuser low is a bare marker), req_tlast closes the text.
// At each word with req_tlast high one verdict word leaves on rsp_:
// rsp_tdata[0] is 1 when the whole text passed, 0 when it was rejected.
// Throughput is one word per cycle while no last word waits on a stalled
// verdict. A word is registered at acceptance and decoded from the input
// register; its verdict is registered in the output register behind rsp_tvalid.
// When rsp_tready is low and a verdict waits, a non-last word still
// advances; a last word holds in the input register and req_tready drops.
// Errors stick until the end of the text; decoder state clears after
// every verdict. Synchronous reset empties both registers and clears the
// decoder state.
module utf8_text_validator_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] has_byte
   input  logic       req_tlast,   // is_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] text_valid, [7:1] zero
);
   import utv_pkg::*;

   logic     in_valid_ff;
   logic     in_valid_in;
   word_type in_word_ff;
   logic     out_valid_ff;
   logic     out_valid_in;
   logic     out_text_ff;
   logic     advance;
   logic     verdict;

   // a word with no verdict never waits on the output register
   assign advance    = in_valid_ff && (!in_word_ff.is_last || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && in_word_ff.is_last) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_word_ff <= '{data_byte: req_tdata, has_byte: req_tuser, is_last: req_tlast};
      end
      if (advance && in_word_ff.is_last) begin
         out_text_ff <= verdict;
      end
   end

   utv_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .word       (in_word_ff),
      .text_valid (verdict)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_text_ff};

endmodule

// ----- src/utv_checker.sv -----
// Port-level checks for the UTF-8 text validator, bound to the top level.
module utv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // a stalled verdict holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("verdict dropped or changed under stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("verdict present after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'd0)
      else $error("nonzero padding in verdict word");

   // with the output empty, the input side never blocks
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && $past(!rsp_tvalid) && !$past(reset) |-> req_tready)
      else $error("input stalled with an empty output");

endmodule

bind utf8_text_validator_unit utv_checker u_utv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
